### rtl/u8dec_pkg.sv
// shared types, constants and the sequence check for the utf-8 decoder
// no dependencies; used by every module of the decoder
package u8dec_pkg;

  localparam int unsigned CpW               = 21;
  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [CpW-1:0] Repl        = 21'h00FFFD;
  localparam logic [CpW-1:0] CpMax       = 21'h10FFFF;
  localparam logic [CpW-1:0] SurrLo      = 21'h00D800;
  localparam logic [CpW-1:0] SurrHi      = 21'h00DFFF;
  localparam logic [CpW-1:0] MinLen2     = 21'h000080;
  localparam logic [CpW-1:0] MinLen3     = 21'h000800;
  localparam logic [CpW-1:0] MinLen4     = 21'h010000;

  localparam logic [7:0] Lead2Mask  = 8'hE0;
  localparam logic [7:0] Lead2Val   = 8'hC0;
  localparam logic [7:0] Lead3Mask  = 8'hF0;
  localparam logic [7:0] Lead3Val   = 8'hE0;
  localparam logic [7:0] Lead4Mask  = 8'hF8;
  localparam logic [7:0] Lead4Val   = 8'hF0;
  localparam logic [7:0] ContMask   = 8'hC0;
  localparam logic [7:0] ContVal    = 8'h80;
  localparam logic [7:0] AsciiLimit = 8'h80;

  localparam logic [2:0] LenNone = 3'd0;
  localparam logic [2:0] Len2    = 3'd2;
  localparam logic [2:0] Len3    = 3'd3;
  localparam logic [2:0] Len4    = 3'd4;

  // one decoded request: n_repl replacement characters, then optionally cp
  typedef struct packed {
    logic [2:0]     n_repl;
    logic           has_cp;
    logic [CpW-1:0] cp;
    logic           eot;
  } job_t;

  function automatic logic seq_bad(input logic [2:0] len, input logic [CpW-1:0] cp);
    logic overlong;
    overlong = ((len == Len2) && (cp < MinLen2)) ||
               ((len == Len3) && (cp < MinLen3)) ||
               ((len == Len4) && (cp < MinLen4));
    return overlong || (cp > CpMax) || ((cp >= SurrLo) && (cp <= SurrHi));
  endfunction

endpackage

### rtl/u8dec_front.sv
// front end: holds the open sequence; each byte gives at most one queued request
// depends on u8dec_pkg
module u8dec_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        in_byte_i,
  input  logic              end_of_text_i,
  output logic              push_o,
  output u8dec_pkg::job_t   job_o
);

  logic [1:0]  pend_q, pend_d;
  logic [2:0]  len_q, len_d;
  logic [20:0] part_q, part_d;

  logic        is_cont;
  logic [2:0]  cnt_inc;
  logic [20:0] seq_val;
  logic [2:0]  f_len;
  logic [20:0] f_bits;
  logic        fresh;
  u8dec_pkg::job_t job;

  assign is_cont = (in_byte_i & u8dec_pkg::ContMask) == u8dec_pkg::ContVal;
  assign cnt_inc = {1'b0, pend_q} + 3'd1;
  assign seq_val = {part_q[14:0], in_byte_i[5:0]};

  always_comb begin
    f_len  = u8dec_pkg::LenNone;
    f_bits = '0;
    if ((in_byte_i & u8dec_pkg::Lead2Mask) == u8dec_pkg::Lead2Val) begin
      f_len  = u8dec_pkg::Len2;
      f_bits = {16'd0, in_byte_i[4:0]};
    end else if ((in_byte_i & u8dec_pkg::Lead3Mask) == u8dec_pkg::Lead3Val) begin
      f_len  = u8dec_pkg::Len3;
      f_bits = {17'd0, in_byte_i[3:0]};
    end else if ((in_byte_i & u8dec_pkg::Lead4Mask) == u8dec_pkg::Lead4Val) begin
      f_len  = u8dec_pkg::Len4;
      f_bits = {18'd0, in_byte_i[2:0]};
    end
  end

  always_comb begin
    job     = '0;
    job.eot = end_of_text_i;
    pend_d  = pend_q;
    len_d   = len_q;
    part_d  = part_q;
    fresh   = 1'b0;
    if (len_q == u8dec_pkg::LenNone) begin
      fresh = 1'b1;
    end else if (is_cont) begin
      if (cnt_inc >= len_q) begin
        if (u8dec_pkg::seq_bad(len_q, seq_val)) begin
          job.n_repl = len_q;
        end else begin
          job.has_cp = 1'b1;
          job.cp     = seq_val;
        end
        pend_d = '0;
        len_d  = u8dec_pkg::LenNone;
        part_d = '0;
      end else if (end_of_text_i) begin
        job.n_repl = cnt_inc;
        pend_d     = '0;
        len_d      = u8dec_pkg::LenNone;
        part_d     = '0;
      end else begin
        pend_d = cnt_inc[1:0];
        part_d = seq_val;
      end
    end else begin
      // broken sequence: replace what was taken, then decode this byte afresh
      job.n_repl = {1'b0, pend_q};
      pend_d     = '0;
      len_d      = u8dec_pkg::LenNone;
      part_d     = '0;
      fresh      = 1'b1;
    end
    if (fresh) begin
      if (in_byte_i < u8dec_pkg::AsciiLimit) begin
        job.has_cp = 1'b1;
        job.cp     = {13'd0, in_byte_i};
      end else if ((f_len != u8dec_pkg::LenNone) && !end_of_text_i) begin
        len_d  = f_len;
        pend_d = 2'd1;
        part_d = f_bits;
      end else begin
        job.n_repl = job.n_repl + 3'd1;
      end
    end
  end

  assign job_o  = job;
  assign push_o = accept_i && ((job.n_repl != 3'd0) || job.has_cp);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      len_q  <= u8dec_pkg::LenNone;
      part_q <= '0;
    end else if (accept_i) begin
      pend_q <= pend_d;
      len_q  <= len_d;
      part_q <= part_d;
    end
  end

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q == u8dec_pkg::LenNone) |-> (pend_q == 2'd0 && part_q == '0))
    else $error("idle with bytes pending");

  a_open_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q != u8dec_pkg::LenNone) |-> (pend_q != 2'd0 && {1'b0, pend_q} < len_q))
    else $error("pending count out of range for open sequence");

  a_eot_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && end_of_text_i) |=> (len_q == u8dec_pkg::LenNone))
    else $error("sequence left open after end of text");

endmodule

### rtl/u8dec_queue.sv
// short request queue between the front end and the output sequencer
// depends on u8dec_pkg
module u8dec_queue #(
  parameter int unsigned Depth = u8dec_pkg::QueueDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  u8dec_pkg::job_t push_data_i,
  input  logic            pop_i,
  output u8dec_pkg::job_t pop_data_o,
  output logic            full_o,
  output logic            empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  u8dec_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o     = count_q == CntW'(Depth);
  assign empty_o    = count_q == '0;
  assign pop_data_o = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");

endmodule

### rtl/u8dec_back.sv
// output sequencer: plays each request as one code point per unstalled cycle
// depends on u8dec_pkg
module u8dec_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  u8dec_pkg::job_t q_data_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [20:0]     code_point_o,
  output logic            last_of_run_o,
  output logic            text_done_o
);

  u8dec_pkg::job_t job_q, job_d;
  logic [1:0]      idx_q, idx_d;
  logic            busy_q, busy_d;

  logic [2:0] total;
  logic       last;
  logic       fire;

  assign total = job_q.n_repl + {2'd0, job_q.has_cp};
  assign last  = ({1'b0, idx_q} + 3'd1) == total;
  assign fire  = busy_q && !out_stall_i;

  assign out_valid_o   = busy_q;
  assign code_point_o  = ({1'b0, idx_q} < job_q.n_repl) ? u8dec_pkg::Repl : job_q.cp;
  assign last_of_run_o = last;
  assign text_done_o   = last && job_q.eot;

  always_comb begin
    q_pop_o = !q_empty_i && (!busy_q || (fire && last));
    job_d   = job_q;
    idx_d   = idx_q;
    busy_d  = busy_q;
    if (q_pop_o) begin
      job_d  = q_data_i;
      idx_d  = '0;
      busy_d = 1'b1;
    end else if (fire && last) begin
      busy_d = 1'b0;
    end else if (fire) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      busy_q <= busy_d;
    end
  end

  a_job_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (total != 3'd0 && total <= 3'd4))
    else $error("request with no or too many results");

  a_idx_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> ({1'b0, idx_q} < total))
    else $error("result index past end of request");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && out_stall_i) |=> (busy_q && $stable(idx_q)))
    else $error("sequencer advanced while stalled");

endmodule

### rtl/utf8_decoder_with_replacement.sv
// UTF-8 byte stream to code point decoder with U+FFFD replacement. A byte is
// taken every cycle while the request queue between the front end and the
// output sequencer has room; a byte gives 0 to 4 code points and the sequencer
// delivers one per cycle while out_stall_i is low. With the queue empty
// and the sequencer idle, a taken byte's request is written into the queue
// and then loaded into the sequencer, which raises out_valid_o. QueueDepth
// sets how much output stall is absorbed.
// depends on u8dec_pkg, u8dec_front, u8dec_queue, u8dec_back
module utf8_decoder_with_replacement #(
  parameter int unsigned QueueDepth = u8dec_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [20:0] code_point_o,
  output logic        last_of_run_o,
  output logic        text_done_o
);

  logic            accept;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_empty;
  u8dec_pkg::job_t push_job;
  u8dec_pkg::job_t pop_job;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  u8dec_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .in_byte_i     (in_byte_i),
    .end_of_text_i (end_of_text_i),
    .push_o        (push),
    .job_o         (push_job)
  );

  u8dec_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  u8dec_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_data_i      (pop_job),
    .q_pop_o       (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .code_point_o  (code_point_o),
    .last_of_run_o (last_of_run_o),
    .text_done_o   (text_done_o)
  );

endmodule
